@@ design/g711_pkg.sv @@
// g711_pkg: shared constants for the G.711 companding codec.
// Used by g711_encoder, g711_decoder and g711_companding_codec_unit; no dependencies.
`default_nettype none

package g711_pkg;

   // Companding law codes (law_select register)
   localparam logic LAW_MU = 1'b0;
   localparam logic LAW_A  = 1'b1;

   // Item action codes
   localparam logic ACTION_ENCODE = 1'b0;
   localparam logic ACTION_DECODE = 1'b1;

   // Mu-law clip level and bias, A-law even-bit inversion mask
   localparam logic [14:0] MU_CLIP = 15'd32635;
   localparam logic [14:0] MU_BIAS = 15'd132;
   localparam logic [7:0]  A_XOR   = 8'h55;

   // One input item as held in the input register
   typedef struct packed {
      logic               action;
      logic signed [15:0] pcm_sample;
      logic [7:0]         code_in;
   } req_item_type;

endpackage : g711_pkg

`default_nettype wire

@@ design/g711_encoder.sv @@
// g711_encoder: linear 16-bit PCM to 8-bit G.711 code, mu-law or A-law.
// Purely combinational; uses constants from g711_pkg.
`default_nettype none

module g711_encoder (
   input  wire logic               law_select,
   input  wire logic signed [15:0] pcm_sample,
   output logic [7:0]              code_out
);

   logic [15:0] raw;
   logic        neg;

   // mu-law path
   logic [16:0] mu_mag;
   logic [14:0] mu_clip;
   logic [14:0] mu_biased;
   logic [2:0]  mu_seg;
   logic [3:0]  mu_shamt;
   logic [14:0] mu_shifted;
   logic [7:0]  mu_code;

   // A-law path
   logic [14:0] a_mag;
   logic [2:0]  a_seg;
   logic [3:0]  a_shamt;
   logic [14:0] a_shifted;
   logic [7:0]  a_code;

   assign raw = pcm_sample;
   assign neg = raw[15];

   // mu-law: magnitude, clip, bias, segment from leading one, mantissa, invert
   always_comb begin
      mu_mag    = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      mu_clip   = (mu_mag > {2'b00, g711_pkg::MU_CLIP}) ? g711_pkg::MU_CLIP : mu_mag[14:0];
      mu_biased = mu_clip + g711_pkg::MU_BIAS;
      // biased value is at least 132, so bit 7 is the lowest possible leading one
      mu_seg = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (mu_biased[7 + i]) begin
            mu_seg = 3'(i);
         end
      end
      mu_shamt   = {1'b0, mu_seg} + 4'd3;
      mu_shifted = mu_biased >> mu_shamt;
      mu_code    = ~{neg, mu_seg, mu_shifted[3:0]};
   end

   // A-law: ones'-complement magnitude, segment, mantissa, toggle even bits
   always_comb begin
      a_mag = neg ? ~raw[14:0] : raw[14:0];
      a_seg = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (a_mag[7 + i]) begin
            a_seg = 3'(i);
         end
      end
      // segment 0 and 1 share the same mantissa position
      a_shamt   = (a_seg == 3'd0) ? 4'd4 : ({1'b0, a_seg} + 4'd3);
      a_shifted = a_mag >> a_shamt;
      a_code    = {~neg, a_seg, a_shifted[3:0]} ^ g711_pkg::A_XOR;
   end

   assign code_out = (law_select == g711_pkg::LAW_A) ? a_code : mu_code;

endmodule : g711_encoder

`default_nettype wire

@@ design/g711_decoder.sv @@
// g711_decoder: 8-bit G.711 code to linear 16-bit PCM, mu-law or A-law.
// Purely combinational; uses constants from g711_pkg.
`default_nettype none

module g711_decoder (
   input  wire logic        law_select,
   input  wire logic [7:0]  code_in,
   output logic signed [15:0] pcm_out
);

   // mu-law path
   logic [7:0]  mu_u;
   logic [7:0]  mu_base;
   logic [14:0] mu_scaled;
   logic [14:0] mu_t;
   logic [15:0] mu_pcm;

   // A-law path
   logic [7:0]  a_c;
   logic [7:0]  a_step;
   logic [8:0]  a_base;
   logic [14:0] a_t;
   logic [15:0] a_pcm;

   // mu-law: ((mant*8 + bias) << seg) - bias, sign from the inverted code
   always_comb begin
      mu_u      = ~code_in;
      mu_base   = {1'b0, mu_u[3:0], 3'b000} + 8'(g711_pkg::MU_BIAS);
      mu_scaled = {7'b0, mu_base} << mu_u[6:4];
      mu_t      = mu_scaled - g711_pkg::MU_BIAS;
      mu_pcm    = mu_u[7] ? (16'h0000 - {1'b0, mu_t}) : {1'b0, mu_t};
   end

   // A-law: half-step midpoint in segment 0, implied leading one above it
   always_comb begin
      a_c    = code_in ^ g711_pkg::A_XOR;
      a_step = {a_c[3:0], 4'b0000};
      a_base = {1'b0, a_step} + 9'h108;
      if (a_c[6:4] == 3'd0) begin
         a_t = {7'b0, a_step} + 15'd8;
      end else begin
         a_t = {6'b0, a_base} << (a_c[6:4] - 3'd1);
      end
      a_pcm = a_c[7] ? {1'b0, a_t} : (16'h0000 - {1'b0, a_t});
   end

   assign pcm_out = (law_select == g711_pkg::LAW_A) ? a_pcm : mu_pcm;

endmodule : g711_decoder

`default_nettype wire

@@ design/g711_companding_codec_unit.sv @@
// g711_companding_codec_unit: top level of the G.711 mu-law / A-law codec.
// Depends on g711_pkg, g711_encoder and g711_decoder.
`default_nettype none

// Converts one item per clock unless rsp_stall holds it: action 0 encodes
// req_pcm_sample into a G.711 byte on rsp_code_out (rsp_pcm_out reads 0),
// action 1 decodes req_code_in into a linear sample on rsp_pcm_out
// (rsp_code_out reads 0). csr_write_data selects the law (0 mu-law, 1 A-law)
// and resets to mu-law; write it only while no item is in flight. Each item
// passes the input register and then the result register, with the conversion
// logic between them. Back-pressure on rsp_stall holds the result register;
// once the input register is also full it is held too and req_stall rises.
module g711_companding_codec_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_write_en,
   input  wire logic               csr_write_data,
   // input items
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic signed [15:0] req_pcm_sample,
   input  wire logic [7:0]         req_code_in,
   // result items
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_code_out,
   output logic signed [15:0]      rsp_pcm_out
);

   logic                  law_ff, law_in;
   logic                  in_valid_ff, in_valid_in;
   g711_pkg::req_item_type in_item_ff, in_item_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_code_ff, out_code_in;
   logic signed [15:0]    out_pcm_ff, out_pcm_in;

   logic                  out_open;
   logic                  in_open;
   logic [7:0]            enc_code;
   logic signed [15:0]    dec_pcm;

   // Handshake: result register frees when empty or taken, input register follows
   assign out_open  = !out_valid_ff || !rsp_stall;
   assign in_open   = !in_valid_ff || out_open;
   assign req_stall = !in_open;

   // Law register
   assign law_in = csr_write_en ? csr_write_data : law_ff;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (in_open) begin
         in_valid_in           = req_valid;
         in_item_in.action     = req_action;
         in_item_in.pcm_sample = req_pcm_sample;
         in_item_in.code_in    = req_code_in;
      end
   end

   // Conversion units
   g711_encoder u_enc (
      .law_select (law_ff),
      .pcm_sample (in_item_ff.pcm_sample),
      .code_out   (enc_code)
   );

   g711_decoder u_dec (
      .law_select (law_ff),
      .code_in    (in_item_ff.code_in),
      .pcm_out    (dec_pcm)
   );

   // Result register: unused field of each item reads zero
   always_comb begin
      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;
      out_pcm_in   = out_pcm_ff;
      if (out_open) begin
         out_valid_in = in_valid_ff;
         if (in_item_ff.action == g711_pkg::ACTION_DECODE) begin
            out_code_in = 8'h00;
            out_pcm_in  = dec_pcm;
         end else begin
            out_code_in = enc_code;
            out_pcm_in  = 16'sh0000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         law_ff       <= g711_pkg::LAW_MU;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         law_ff       <= law_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_code_ff <= out_code_in;
      out_pcm_ff  <= out_pcm_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_code_out = out_code_ff;
   assign rsp_pcm_out  = out_pcm_ff;

endmodule : g711_companding_codec_unit

`default_nettype wire

@@ dv/tb.sv @@
// tb: self-checking testbench for g711_companding_codec_unit (mu-law / A-law codec).
// Depends on g711_pkg and the codec RTL; predicts every result in SV and checks
// each output item against the oldest expected conversion.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 4;

   // Expected output item: encoded byte and decoded sample
   typedef struct packed {
      logic [7:0]  code;
      logic [15:0] pcm;
   } conv_result_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_write_en   = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid      = 1'b0;
   logic        req_action     = 1'b0;
   logic [15:0] req_pcm_sample = '0;
   logic [7:0]  req_code_in    = '0;
   logic        rsp_stall      = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_code_out;
   logic [15:0] rsp_pcm_out;

   conv_result_type expected_results[$];
   logic            current_law    = g711_pkg::LAW_MU;
   bit              stall_enabled  = 1'b0;
   int              hold_requests  = 0;
   int              mismatch_count = 0;
   int              cycle_count    = 0;

   g711_companding_codec_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_pcm_sample (req_pcm_sample),
      .req_code_in    (req_code_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_out   (rsp_code_out),
      .rsp_pcm_out    (rsp_pcm_out)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int leading_one(int v);
      int pos;
      pos = 0;
      for (int b = 0; b < 16; b++) begin
         if (v[b]) pos = b;
      end
      return pos;
   endfunction

   // mu-law: clip, bias, segment from leading one, invert
   function automatic logic [7:0] mu_compress(logic [15:0] s);
      logic       neg;
      int         mag;
      int         seg;
      logic [3:0] mant;
      neg = s[15];
      mag = neg ? 65536 - int'(s) : int'(s);
      if (mag > int'(g711_pkg::MU_CLIP)) mag = int'(g711_pkg::MU_CLIP);
      mag  = mag + int'(g711_pkg::MU_BIAS);
      seg  = leading_one(mag) - 7;
      mant = 4'(mag >> (seg + 3));
      return ~{neg, 3'(seg), mant};
   endfunction

   function automatic logic [15:0] mu_expand(logic [7:0] c);
      logic [7:0] u;
      int         t;
      u = ~c;
      t = (((int'(u[3:0]) << 3) + int'(g711_pkg::MU_BIAS)) << u[6:4])
          - int'(g711_pkg::MU_BIAS);
      return u[7] ? 16'(-t) : 16'(t);
   endfunction

   // A-law: ones'-complement magnitude, segment 0 covers magnitudes below 256
   function automatic logic [7:0] a_compress(logic [15:0] s);
      logic        neg;
      logic [15:0] mag;
      int          seg;
      logic [3:0]  mant;
      neg = s[15];
      mag = neg ? ~s : s;
      if ((mag >> 3) <= 31) seg = 0;
      else seg = leading_one(int'(mag >> 3)) - 4;
      mant = (seg == 0) ? mag[7:4] : 4'(mag >> (seg + 3));
      return {~neg, 3'(seg), mant} ^ g711_pkg::A_XOR;
   endfunction

   function automatic logic [15:0] a_expand(logic [7:0] c);
      logic [7:0] a;
      int         seg;
      int         t;
      a   = c ^ g711_pkg::A_XOR;
      seg = a[6:4];
      t   = int'(a[3:0]) << 4;
      if (seg == 0) t = t + 8;
      else t = (t + 264) << (seg - 1);
      return a[7] ? 16'(t) : 16'(-t);
   endfunction

   // expected item for the law in force; the unused field reads 0
   function automatic conv_result_type g711_convert(logic act, logic [15:0] pcm,
                                                    logic [7:0] code);
      conv_result_type r;
      r = '0;
      if (act == g711_pkg::ACTION_ENCODE) begin
         r.code = (current_law == g711_pkg::LAW_A) ? a_compress(pcm) : mu_compress(pcm);
      end else begin
         r.pcm = (current_law == g711_pkg::LAW_A) ? a_expand(code) : mu_expand(code);
      end
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // full-range samples half the time, small magnitudes for the low segments
   function automatic logic [15:0] random_sample();
      logic [15:0] s;
      if ($urandom_range(0, 1)) begin
         s = 16'($urandom);
      end else begin
         s = 16'($urandom_range(0, 511));
         if ($urandom_range(0, 1)) s = -s;
      end
      return s;
   endfunction

   // ---------------------------------------------------------------- result side

   // receiver stalls: random runs, plus long holds on request
   always @(posedge clock) begin : drive_rsp_stall
      int stall_left;
      int hold_served;
      int n;
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         stall_left  = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (stall_enabled) begin
         n = idle_length();
         rsp_stall  <= (n > 0);
         stall_left = (n > 0) ? n - 1 : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted item with the oldest expectation
   always @(posedge clock) begin : check_results
      conv_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected item, expected none actual code_out=%02h pcm_out=%04h",
                     $time, rsp_code_out, rsp_pcm_out);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_code_out !== want.code) begin
               $display("%0t: code_out expected %02h actual %02h",
                        $time, want.code, rsp_code_out);
               mismatch_count++;
            end
            if (rsp_pcm_out !== want.pcm) begin
               $display("%0t: pcm_out expected %04h actual %04h",
                        $time, want.pcm, rsp_pcm_out);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- input side

   // offer one item and hold it until accepted; valid stays high afterwards
   task automatic send_item(logic act, logic [15:0] pcm, logic [7:0] code);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_pcm_sample <= pcm;
      req_code_in    <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(g711_convert(act, pcm, code));
   endtask

   task automatic idle_sender(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop sending and let every outstanding item come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_law(logic law);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= law;
      @(posedge clock);
      csr_write_en <= 1'b0;
      current_law  = law;
   endtask

   task automatic send_random(int count, bit gaps);
      for (int i = 0; i < count; i++) begin
         if (gaps) idle_sender(idle_length());
         send_item($urandom_range(0, 1) ? g711_pkg::ACTION_DECODE : g711_pkg::ACTION_ENCODE,
                   random_sample(), 8'($urandom));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // zero, -1, A-law segment edge, extremes, just past the mu-law clip level
   task automatic test_directed();
      logic [15:0] samples[7];
      logic [7:0]  codes[5];
      samples = '{16'h0000, 16'hFFFF, 16'd255, 16'h7FFF, 16'h8000,
                  16'd32636, 16'h8084};  // last one is -32636
      codes   = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h55};
      for (int k = 0; k < 2; k++) begin
         set_law((k == 0) ? g711_pkg::LAW_MU : g711_pkg::LAW_A);
         foreach (samples[i]) send_item(g711_pkg::ACTION_ENCODE, samples[i], 8'($urandom));
         foreach (codes[i]) send_item(g711_pkg::ACTION_DECODE, 16'($urandom), codes[i]);
      end
   endtask

   // random items with gaps on both sides, law alternating between phases
   task automatic test_random_mixed();
      stall_enabled = 1'b1;
      for (int phase = 0; phase < 4; phase++) begin
         set_law((phase % 2) ? g711_pkg::LAW_A : g711_pkg::LAW_MU);
         send_random(300, 1'b1);
      end
   endtask

   // back-to-back items with no stalls at all
   task automatic test_full_rate();
      stall_enabled = 1'b0;
      set_law(g711_pkg::LAW_MU);
      send_random(100, 1'b0);
   endtask

   // long receiver hold while the sender keeps offering, then a full drain
   task automatic test_backpressure();
      stall_enabled = 1'b0;
      set_law(g711_pkg::LAW_A);
      hold_requests++;
      send_random(60, 1'b0);
      wait_drained();
      stall_enabled = 1'b1;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mixed();
      test_full_rate();
      test_backpressure();
      wait_drained();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
